// File: rtl/utf8c_pkg.sv
// ----------------------------------------------------------------------------
// utf8c_pkg
// shared types and constants of the utf-8 codec
// ----------------------------------------------------------------------------
package utf8c_pkg;

  localparam int PointW  = 21;
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;

  typedef logic [PointW-1:0] point_t;

  // one unit of work for the back end
  typedef struct packed {
    logic       is_enc;  // encode job: emit cnt+1 bytes
    logic [1:0] cnt;     // bytes minus one
    point_t     point;   // code point
    logic       bad;     // invalid lead result
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/utf8c_front.sv
// ----------------------------------------------------------------------------
// utf8c_front
// accepts units, holds direction and decode state, queues result jobs
// ----------------------------------------------------------------------------
module utf8c_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  utf8c_pkg::point_t  in_unit,
  input  utf8c_pkg::q_stat_t q_stat,
  output logic               push,
  output utf8c_pkg::job_t    push_job
);

  logic               dir;
  logic [1:0]         pend;
  logic [1:0]         pend_next;
  utf8c_pkg::point_t  part;
  utf8c_pkg::point_t  part_next;
  utf8c_pkg::point_t  merged;
  logic [7:0]         b;
  logic               acc;
  logic               emit;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign b        = in_unit[7:0];

  always_comb begin
    case (pend)
      2'd1:    merged = part | {15'b0, b[5:0]};
      2'd2:    merged = part | {9'b0, b[5:0], 6'b0};
      default: merged = part | {3'b0, b[5:0], 12'b0};
    endcase
  end

  always_comb begin
    pend_next     = pend;
    part_next     = part;
    emit          = 1'b0;
    push_job      = '0;
    push_job.point = in_unit;
    if (dir == utf8c_pkg::DIR_ENCODE) begin
      emit         = 1'b1;
      push_job.is_enc = 1'b1;
      if (in_unit[20:7] == '0)       push_job.cnt = 2'd0;
      else if (in_unit[20:11] == '0) push_job.cnt = 2'd1;
      else if (in_unit[20:16] == '0) push_job.cnt = 2'd2;
      else                           push_job.cnt = 2'd3;
    end else if (pend != 2'd0) begin
      pend_next = pend - 2'd1;
      if (pend == 2'd1) begin
        emit           = 1'b1;
        push_job.point = merged;
        part_next      = '0;
      end else begin
        part_next = merged;
      end
    end else if (!b[7]) begin
      emit           = 1'b1;
      push_job.point = {13'b0, b};
    end else if (b[7:5] == 3'b110) begin
      part_next = {10'b0, b[4:0], 6'b0};
      pend_next = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      part_next = {5'b0, b[3:0], 12'b0};
      pend_next = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      part_next = {b[2:0], 18'b0};
      pend_next = 2'd3;
    end else begin
      emit           = 1'b1;
      push_job.point = '0;
      push_job.bad   = 1'b1;
    end
  end

  assign push = acc && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir  <= utf8c_pkg::DIR_ENCODE;
      pend <= 2'd0;
      part <= '0;
    end else if (cfg_wen) begin
      dir  <= cfg_wdata;
      pend <= 2'd0;
      part <= '0;
    end else if (acc) begin
      pend <= pend_next;
      part <= part_next;
    end
  end

endmodule

// File: rtl/utf8c_queue.sv
// ----------------------------------------------------------------------------
// utf8c_queue
// short job queue between front and back end
// ----------------------------------------------------------------------------
module utf8c_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  utf8c_pkg::job_t    push_job,
  input  logic               pop,
  output utf8c_pkg::job_t    head,
  output utf8c_pkg::q_stat_t stat
);

  utf8c_pkg::job_t               mem [utf8c_pkg::QDepth];
  logic [utf8c_pkg::QPtrW-1:0]   wr_ptr;
  logic [utf8c_pkg::QPtrW-1:0]   rd_ptr;
  logic [utf8c_pkg::QCntW-1:0]   count;

  assign stat.full  = (count == utf8c_pkg::QCntW'(utf8c_pkg::QDepth));
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/utf8c_back.sv
// ----------------------------------------------------------------------------
// utf8c_back
// takes jobs from the queue and streams one result per cycle while out_ready is high
// ----------------------------------------------------------------------------
module utf8c_back (
  input  logic               clk,
  input  logic               rst,
  input  utf8c_pkg::q_stat_t q_stat,
  input  utf8c_pkg::job_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output utf8c_pkg::point_t  out_value,
  output logic               out_last,
  output logic               out_bad
);

  utf8c_pkg::job_t   job;
  logic              job_valid;
  logic [1:0]        idx;
  logic              load_out;
  logic              finishing;
  logic [7:0]        enc_byte;
  logic [5:0]        six;
  utf8c_pkg::point_t value_next;
  logic              last_next;

  assign load_out  = !out_valid || out_ready;
  assign finishing = job_valid && load_out && (idx == job.cnt);
  assign pop       = !q_stat.empty && (!job_valid || finishing);

  // six payload bits of the byte at position idx
  always_comb begin
    case (job.cnt - idx)
      2'd0:    six = job.point[5:0];
      2'd1:    six = job.point[11:6];
      2'd2:    six = job.point[17:12];
      default: six = {3'b0, job.point[20:18]};
    endcase
  end

  always_comb begin
    if (idx != 2'd0) begin
      enc_byte = utf8c_pkg::CONT_MARK | {2'b0, six};
    end else begin
      case (job.cnt)
        2'd0:    enc_byte = {1'b0, job.point[6:0]};
        2'd1:    enc_byte = utf8c_pkg::LEAD2_MARK | {3'b0, job.point[10:6]};
        2'd2:    enc_byte = utf8c_pkg::LEAD3_MARK | {4'b0, job.point[15:12]};
        default: enc_byte = utf8c_pkg::LEAD4_MARK | {5'b0, job.point[20:18]};
      endcase
    end
  end

  always_comb begin
    if (job.is_enc) begin
      value_next = {13'b0, enc_byte};
      last_next  = (idx == job.cnt);
    end else begin
      value_next = job.point;
      last_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        job_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (finishing) begin
        job_valid <= 1'b0;
      end else if (job_valid && load_out) begin
        idx <= idx + 2'd1;
      end
      if (load_out) out_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job <= head;
    if (load_out) begin
      out_value <= value_next;
      out_last  <= last_next;
      out_bad   <= job.bad && !job.is_enc;
    end
  end

endmodule

// File: rtl/utf8_codec.sv
// ----------------------------------------------------------------------------
// utf8_codec
// utf-8 encoder / decoder with a direction register
// ----------------------------------------------------------------------------
// input stream s_*: one unit per transaction, a code point when encoding or a
// byte in the low 8 bits when decoding. output stream m_*: one result per
// transaction, a utf-8 byte with tlast on the final byte of a sequence, or a
// decoded code point with tlast always set and tuser flagging an invalid lead
// (data then zero). cfg_wen/cfg_wdata write the direction (0 encode, 1
// decode) and clear the decode state; write only while the block is idle.
// throughput: a unit is taken every cycle while the job queue has room; the
// output serializer gives one result per cycle while m_tready is high, so an
// encoded code point gives one to four results in turn. decode lead and
// middle bytes make no result and take no output transaction.
// stall: when m_tready is low the output register holds, the queue fills and
// s_tready drops once four jobs wait. reset (rst, synchronous) selects
// encode, clears the decode state and empties the queue.
// ----------------------------------------------------------------------------
module utf8_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // unit[20:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // value[20:0]
  output logic        m_tlast,
  output logic        m_tuser    // invalid_lead
);

  logic               push;
  logic               pop;
  utf8c_pkg::job_t    push_job;
  utf8c_pkg::job_t    head;
  utf8c_pkg::q_stat_t q_stat;
  utf8c_pkg::point_t  out_value;

  utf8c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_unit   (s_tdata[20:0]),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  utf8c_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  utf8c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (out_value),
    .out_last  (m_tlast),
    .out_bad   (m_tuser)
  );

  assign m_tdata = {3'b0, out_value};

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_stat.empty))
    else $error("pop from empty queue");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
    else $error("invalid lead result not zero with last");

  a_ready_tracks_room: assert property (@(posedge clk) disable iff (rst)
    (q_stat.empty && !push) |=> s_tready)
    else $error("input stalled with empty queue");

endmodule

// File: tb/sv/utf8_codec_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_codec_tb
// self-checking bench for the utf-8 encoder / decoder
// ----------------------------------------------------------------------------
// a scoreboard predicts the byte stream of each code point in encode mode and
// the assembled code points in decode mode, and checks every output
// transaction in order. directed units cover the sequence-length boundaries,
// the widest code points, invalid leads and unchecked continuations. random
// phases switch the direction between them, mostly send well-formed byte
// sequences with random content when decoding, and idle both stream sides at
// random.
// ----------------------------------------------------------------------------

typedef struct packed {
  utf8c_pkg::point_t value;
  logic              last;
  logic              bad;
} codec_result_t;

class codec_scoreboard;
  logic              dir;
  logic [1:0]        pending;
  utf8c_pkg::point_t partial;
  codec_result_t     result_q[$];
  int                errors;
  int                units;
  int                enc_units;
  int                results;
  int                invalids;

  function void clear_state(logic d);
    dir     = d;
    pending = '0;
    partial = '0;
  endfunction

  function void push_result(utf8c_pkg::point_t value, logic last, logic bad);
    codec_result_t r;
    r.value = value;
    r.last  = last;
    r.bad   = bad;
    result_q = {result_q, r};
    if (bad) invalids++;
  endfunction

  function void note_unit(utf8c_pkg::point_t unit);
    logic [7:0] b;
    int         sh;
    b = unit[7:0];
    units++;
    if (dir == utf8c_pkg::DIR_ENCODE) begin
      enc_units++;
      if (unit < 21'h80) begin
        push_result(unit, 1'b1, 1'b0);
      end else if (unit < 21'h800) begin
        push_result(utf8c_pkg::point_t'(unit[10:6]) | utf8c_pkg::point_t'(utf8c_pkg::LEAD2_MARK),
                    1'b0, 1'b0);
        push_result(utf8c_pkg::point_t'(unit[5:0]) | utf8c_pkg::point_t'(utf8c_pkg::CONT_MARK),
                    1'b1, 1'b0);
      end else if (unit < 21'h10000) begin
        push_result(utf8c_pkg::point_t'(unit[15:12]) | utf8c_pkg::point_t'(utf8c_pkg::LEAD3_MARK),
                    1'b0, 1'b0);
        push_result(utf8c_pkg::point_t'(unit[11:6]) | utf8c_pkg::point_t'(utf8c_pkg::CONT_MARK),
                    1'b0, 1'b0);
        push_result(utf8c_pkg::point_t'(unit[5:0]) | utf8c_pkg::point_t'(utf8c_pkg::CONT_MARK),
                    1'b1, 1'b0);
      end else begin
        push_result(utf8c_pkg::point_t'(unit[20:18]) | utf8c_pkg::point_t'(utf8c_pkg::LEAD4_MARK),
                    1'b0, 1'b0);
        push_result(utf8c_pkg::point_t'(unit[17:12]) | utf8c_pkg::point_t'(utf8c_pkg::CONT_MARK),
                    1'b0, 1'b0);
        push_result(utf8c_pkg::point_t'(unit[11:6]) | utf8c_pkg::point_t'(utf8c_pkg::CONT_MARK),
                    1'b0, 1'b0);
        push_result(utf8c_pkg::point_t'(unit[5:0]) | utf8c_pkg::point_t'(utf8c_pkg::CONT_MARK),
                    1'b1, 1'b0);
      end
    end else if (pending != 2'd0) begin
      // continuation, marker bits not checked
      sh      = 6 * (int'(pending) - 1);
      partial = partial | (utf8c_pkg::point_t'(b[5:0]) << sh);
      pending = pending - 2'd1;
      if (pending == 2'd0) begin
        push_result(partial, 1'b1, 1'b0);
        partial = '0;
      end
    end else if (!b[7]) begin
      push_result(utf8c_pkg::point_t'(b), 1'b1, 1'b0);
    end else if ((b & 8'hE0) == utf8c_pkg::LEAD2_MARK) begin
      partial = utf8c_pkg::point_t'(b[4:0]) << 6;
      pending = 2'd1;
    end else if ((b & 8'hF0) == utf8c_pkg::LEAD3_MARK) begin
      partial = utf8c_pkg::point_t'(b[3:0]) << 12;
      pending = 2'd2;
    end else if ((b & 8'hF8) == utf8c_pkg::LEAD4_MARK) begin
      partial = utf8c_pkg::point_t'(b[2:0]) << 18;
      pending = 2'd3;
    end else begin
      push_result('0, 1'b1, 1'b1);
    end
  endfunction

  function void check_result(logic [23:0] data, logic last, logic flag);
    codec_result_t r;
    results++;
    if (result_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected transaction, expected none, actual data=%h last=%b user=%b",
               $time, data, last, flag);
    end else begin
      r = result_q.pop_front();
      if (data !== {3'b000, r.value}) begin
        errors++;
        $display("%0t: tdata expected %h actual %h", $time, {3'b000, r.value}, data);
      end
      if (last !== r.last) begin
        errors++;
        $display("%0t: tlast expected %b actual %b", $time, r.last, last);
      end
      if (flag !== r.bad) begin
        errors++;
        $display("%0t: tuser expected %b actual %b", $time, r.bad, flag);
      end
    end
  endfunction
endclass

module utf8_codec_tb;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_wen   = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;   // unit[20:0]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;          // value[20:0]
  logic        m_tlast;
  logic        m_tuser;          // invalid_lead

  bit              send_idle  = 1'b0;
  bit              recv_idle  = 1'b0;
  int              cfg_writes = 0;
  codec_scoreboard sb         = new();

  utf8c_pkg::point_t enc_directed[$] = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD800,
                                         21'hFFFF, 21'h10000, 21'h1FFFFF};
  utf8c_pkg::point_t dec_directed[$] = '{21'h1FF41, 21'hC3, 21'hA9, 21'hE2, 21'h82, 21'hAC,
                                         21'hF7, 21'hBF, 21'hBF, 21'hBF, 21'h80, 21'hF8,
                                         21'hC2, 21'h41};

  utf8_codec i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_unit(utf8c_pkg::point_t unit);
    int gap;
    gap = send_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, unit};
    do @(posedge clk); while (!s_tready);
    sb.note_unit(unit);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_direction(logic d);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.clear_state(d);
    cfg_writes++;
  endtask

  function automatic utf8c_pkg::point_t random_point();
    case ($urandom_range(0, 4))
      0:       return utf8c_pkg::point_t'($urandom_range(0, 'h7F));
      1:       return utf8c_pkg::point_t'($urandom_range('h80, 'h7FF));
      2:       return utf8c_pkg::point_t'($urandom_range('h800, 'hFFFF));
      3:       return utf8c_pkg::point_t'($urandom_range('h10000, 'h1FFFFF));
      default: return utf8c_pkg::point_t'($urandom);
    endcase
  endfunction

  // byte in the low bits, sometimes with junk above it
  function automatic utf8c_pkg::point_t with_junk(logic [7:0] b);
    logic [12:0] hi;
    hi = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'd0;
    return {hi, b};
  endfunction

  task automatic send_decode_burst();
    int         len;
    int         cont;
    logic [7:0] lead;
    logic [7:0] b;
    if ($urandom_range(0, 6) == 0) begin
      send_unit(utf8c_pkg::point_t'($urandom));
    end else begin
      len = $urandom_range(1, 4);
      case (len)
        1:       lead = 8'($urandom_range(0, 'h7F));
        2:       lead = utf8c_pkg::LEAD2_MARK | 8'($urandom_range(0, 'h1F));
        3:       lead = utf8c_pkg::LEAD3_MARK | 8'($urandom_range(0, 'h0F));
        default: lead = utf8c_pkg::LEAD4_MARK | 8'($urandom_range(0, 'h07));
      endcase
      cont = len - 1;
      // truncated sequence now and then
      if (cont > 0 && $urandom_range(0, 9) == 0) cont--;
      send_unit(with_junk(lead));
      repeat (cont) begin
        b = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                        : (utf8c_pkg::CONT_MARK | 8'($urandom_range(0, 'h3F)));
        send_unit(with_junk(b));
      end
    end
  endtask

  // output side
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = recv_idle ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata, m_tlast, m_tuser);
    end
  end

  initial begin
    int   phase;
    int   target;
    int   burst_start;
    int   burst_end;
    bit   paused;
    logic d;
    phase  = 0;
    paused = 1'b0;
    sb.clear_state(utf8c_pkg::DIR_ENCODE);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    recv_idle = 1'b1;
    foreach (enc_directed[i]) send_unit(enc_directed[i]);
    write_direction(utf8c_pkg::DIR_DECODE);
    foreach (dec_directed[i]) send_unit(dec_directed[i]);
    // direction write in the middle of a sequence drops it
    send_unit(21'hE2);
    write_direction(utf8c_pkg::DIR_DECODE);
    send_unit(21'h41);

    target = sb.units + 330;
    while (sb.units < target) begin
      d = (phase == 0) ? utf8c_pkg::DIR_ENCODE :
          (phase == 1) ? utf8c_pkg::DIR_DECODE : logic'($urandom_range(0, 1));
      write_direction(d);
      send_idle   = ($urandom_range(0, 2) != 0);
      recv_idle   = ($urandom_range(0, 2) != 0);
      burst_start = sb.units;
      burst_end   = sb.units + $urandom_range(20, 50);
      while (sb.units < burst_end && sb.units < target) begin
        if (d == utf8c_pkg::DIR_ENCODE) send_unit(random_point());
        else send_decode_burst();
        if (phase == 1 && !paused && sb.units >= burst_start + 10) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      phase++;
    end

    wait_idle();
    repeat (12) @(posedge clk);
    if (sb.result_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected transactions never arrived", $time, sb.result_q.size());
    end
    $display("%0d units in (%0d encoded, %0d decoded), %0d results checked",
             sb.units, sb.enc_units, sb.units - sb.enc_units, sb.results);
    $display("%0d invalid leads, %0d direction writes, %0d errors",
             sb.invalids, cfg_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("utf8_codec: match");
    end else begin
      $display("utf8_codec: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("utf8_codec: mismatch");
    $finish;
  end

endmodule
